// File: rtl/signed_integer_alu_mul_div_defines.svh
// assertion macros shared by the alu
`ifndef SIGNED_INTEGER_ALU_MUL_DIV_DEFINES_SVH
`define SIGNED_INTEGER_ALU_MUL_DIV_DEFINES_SVH

// implication checked at every clock, off while in reset
`define SIALU_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define SIALU_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/sialu_pkg.sv
// ----------------------------------------------------------------------------
// sialu_pkg
// types and constants of the signed integer alu
// ----------------------------------------------------------------------------
package sialu_pkg;

    localparam int WORD_BITS = 32;
    localparam int KIND_BITS = 3;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [KIND_BITS-1:0] t_kind;

    localparam t_kind KIND_ADD = 3'd0;
    localparam t_kind KIND_SUB = 3'd1;
    localparam t_kind KIND_MUL = 3'd2;
    localparam t_kind KIND_DIV = 3'd3;
    localparam t_kind KIND_MOD = 3'd4;

    typedef struct packed {
        t_kind kind;
        t_word a;
        t_word b;
        t_word dm;
        t_word rem;
        t_word quo;
        t_word aux;
        logic  flip;
        logic  dz;
    } t_item;

    typedef struct packed {
        t_kind kind;
        t_word operand_a;
        t_word operand_b;
    } t_req;

    typedef struct packed {
        t_word result;
        logic  divide_by_zero;
    } t_rsp;

endpackage

// File: rtl/sialu_req_if.sv
// ----------------------------------------------------------------------------
// sialu_req_if
// request channel: valid, ready and operation payload
// ----------------------------------------------------------------------------
interface sialu_req_if;
    logic              valid;
    logic              ready;
    sialu_pkg::t_req   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/sialu_rsp_if.sv
// ----------------------------------------------------------------------------
// sialu_rsp_if
// result channel: valid, ready and result payload
// ----------------------------------------------------------------------------
interface sialu_rsp_if;
    logic              valid;
    logic              ready;
    sialu_pkg::t_rsp   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/sialu_div_stage.sv
// ----------------------------------------------------------------------------
// sialu_div_stage
// one restoring division step: one quotient bit per register stage
// ----------------------------------------------------------------------------
module sialu_div_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  sialu_pkg::t_item i_item,
    output logic             o_valid,
    output sialu_pkg::t_item o_item
);

    logic [sialu_pkg::WORD_BITS:0]   w_trial;
    logic [sialu_pkg::WORD_BITS:0]   w_diff;
    logic                            w_ge;
    sialu_pkg::t_item                n_item;
    logic                            r_valid;
    sialu_pkg::t_item                r_item;

    always_comb begin
        w_trial = {i_item.rem, i_item.quo[sialu_pkg::WORD_BITS-1]};
        w_diff  = w_trial - {1'b0, i_item.dm};
        w_ge    = (w_trial >= {1'b0, i_item.dm});
        n_item  = i_item;
        n_item.rem = w_ge ? w_diff[sialu_pkg::WORD_BITS-1:0]
                          : w_trial[sialu_pkg::WORD_BITS-1:0];
        n_item.quo = {i_item.quo[sialu_pkg::WORD_BITS-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/signed_integer_alu_mul_div.sv
// pipeline: decode, multiply, 32 divide steps, quotient-times-divisor product,
//   final select, each a registered stage
// throughput: one request per cycle; the whole pipeline holds while a result waits
// reset: synchronous active low, clears every stage valid bit; no other state
// ----------------------------------------------------------------------------
// signed_integer_alu_mul_div
// pipelined signed add, subtract, multiply, divide and modulo on 32-bit words
// ----------------------------------------------------------------------------
`include "signed_integer_alu_mul_div_defines.svh"

module signed_integer_alu_mul_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sialu_req_if.sink   i_req,
    sialu_rsp_if.source o_rsp
);

    localparam int NSTAGE = sialu_pkg::WORD_BITS;

    logic             w_adv;
    sialu_pkg::t_word w_am;
    sialu_pkg::t_word w_bm;
    sialu_pkg::t_item n_s0;
    sialu_pkg::t_item r_s0;
    logic             r_v0;
    sialu_pkg::t_item n_s1;
    sialu_pkg::t_item r_s1;
    logic             r_v1;
    sialu_pkg::t_item w_dv [NSTAGE+1];
    logic             w_dvv [NSTAGE+1];
    sialu_pkg::t_word w_q;
    sialu_pkg::t_item n_pa;
    sialu_pkg::t_item r_pa;
    logic             r_va;
    sialu_pkg::t_word w_r;
    sialu_pkg::t_rsp  n_out;
    sialu_pkg::t_rsp  r_out;
    logic             r_vo;

    assign w_adv       = !r_vo || o_rsp.ready;
    assign i_req.ready = w_adv;

    // decode and magnitudes
    always_comb begin
        w_am = i_req.data.operand_a[sialu_pkg::WORD_BITS-1] ? -i_req.data.operand_a
                                                          : i_req.data.operand_a;
        w_bm = i_req.data.operand_b[sialu_pkg::WORD_BITS-1] ? -i_req.data.operand_b
                                                          : i_req.data.operand_b;
        n_s0.kind = i_req.data.kind;
        n_s0.a    = i_req.data.operand_a;
        n_s0.b    = i_req.data.operand_b;
        n_s0.dm   = w_bm;
        n_s0.rem  = '0;
        n_s0.quo  = w_am;
        n_s0.flip = i_req.data.operand_a[sialu_pkg::WORD_BITS-1]
                  ^ i_req.data.operand_b[sialu_pkg::WORD_BITS-1];
        n_s0.dz   = (i_req.data.operand_b == '0)
                  && (i_req.data.kind == sialu_pkg::KIND_DIV
                      || i_req.data.kind == sialu_pkg::KIND_MOD);
        n_s0.aux  = (i_req.data.kind == sialu_pkg::KIND_SUB)
                  ? i_req.data.operand_a - i_req.data.operand_b
                  : i_req.data.operand_a + i_req.data.operand_b;
    end

    // magnitude product
    always_comb begin
        n_s1 = r_s0;
        if (r_s0.kind == sialu_pkg::KIND_MUL) begin
            n_s1.aux = r_s0.quo * r_s0.dm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_va <= 1'b0;
            r_vo <= 1'b0;
        end else if (w_adv) begin
            r_v0 <= i_req.valid;
            r_v1 <= r_v0;
            r_va <= w_dvv[NSTAGE];
            r_vo <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0  <= n_s0;
            r_s1  <= n_s1;
            r_pa  <= n_pa;
            r_out <= n_out;
        end
    end

    assign w_dv[0]  = r_s1;
    assign w_dvv[0] = r_v1;

    for (genvar g = 0; g < NSTAGE; g++) begin : g_div
        sialu_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_dvv[g]),
            .i_item  (w_dv[g]),
            .o_valid (w_dvv[g+1]),
            .o_item  (w_dv[g+1])
        );
    end

    // signed quotient, signed product, quotient times divisor
    always_comb begin
        w_q  = w_dv[NSTAGE].flip ? -w_dv[NSTAGE].quo : w_dv[NSTAGE].quo;
        n_pa = w_dv[NSTAGE];
        n_pa.quo = w_q;
        n_pa.rem = w_q * w_dv[NSTAGE].b;
        if (w_dv[NSTAGE].kind == sialu_pkg::KIND_MUL && w_dv[NSTAGE].flip) begin
            n_pa.aux = -w_dv[NSTAGE].aux;
        end
    end

    // final select
    always_comb begin
        w_r = r_pa.a - r_pa.rem;
        n_out.divide_by_zero = r_pa.dz;
        unique case (r_pa.kind)
            sialu_pkg::KIND_ADD,
            sialu_pkg::KIND_SUB,
            sialu_pkg::KIND_MUL: n_out.result = r_pa.aux;
            sialu_pkg::KIND_DIV: n_out.result = r_pa.quo;
            sialu_pkg::KIND_MOD: n_out.result = w_r[sialu_pkg::WORD_BITS-1] ? -w_r : w_r;
            default:             n_out.result = '0;
        endcase
    end

    assign o_rsp.valid = r_vo;
    assign o_rsp.data  = r_out;

    `SIALU_ASSERT_IMP(a_ready_adv, i_clk, i_rst_n, !o_rsp.ready && r_vo, !i_req.ready, "ready high while result stalled")
    `SIALU_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !w_adv, $stable(r_va) && $stable(w_dvv[NSTAGE]) && $stable(r_v0), "pipeline moved during stall")
    `SIALU_ASSERT_IMP(a_dz_kind, i_clk, i_rst_n, r_va && r_pa.dz, r_pa.kind == sialu_pkg::KIND_DIV || r_pa.kind == sialu_pkg::KIND_MOD, "zero divide flag on non-divide")

endmodule

// File: test/sialu_check.sv
// ----------------------------------------------------------------------------
// sialu_check
// watches the request and result channels, predicts each result and compares
// ----------------------------------------------------------------------------
module sialu_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sialu_req_if       i_req,
    sialu_rsp_if       i_rsp,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_result_count
);

    sialu_pkg::t_rsp expected_q[$];

    function automatic sialu_pkg::t_word negate(sialu_pkg::t_word v);
        return ~v + 1'b1;
    endfunction

    function automatic sialu_pkg::t_word abs_word(sialu_pkg::t_word v);
        return v[sialu_pkg::WORD_BITS-1] ? negate(v) : v;
    endfunction

    function automatic sialu_pkg::t_word mul_word(sialu_pkg::t_word x, sialu_pkg::t_word y);
        sialu_pkg::t_word p;
        p = abs_word(x) * abs_word(y);
        return (x[sialu_pkg::WORD_BITS-1] != y[sialu_pkg::WORD_BITS-1]) ? negate(p) : p;
    endfunction

    function automatic sialu_pkg::t_word div_word(sialu_pkg::t_word x, sialu_pkg::t_word y);
        sialu_pkg::t_word q;
        q = (y == '0) ? '1 : abs_word(x) / abs_word(y);
        return (x[sialu_pkg::WORD_BITS-1] != y[sialu_pkg::WORD_BITS-1]) ? negate(q) : q;
    endfunction

    function automatic sialu_pkg::t_rsp alu_result(sialu_pkg::t_req r);
        sialu_pkg::t_rsp o;
        o.result = '0;
        o.divide_by_zero = 1'b0;
        case (r.kind)
            sialu_pkg::KIND_ADD: o.result = r.operand_a + r.operand_b;
            sialu_pkg::KIND_SUB: o.result = r.operand_a - r.operand_b;
            sialu_pkg::KIND_MUL: o.result = mul_word(r.operand_a, r.operand_b);
            sialu_pkg::KIND_DIV: begin
                o.result = div_word(r.operand_a, r.operand_b);
                o.divide_by_zero = (r.operand_b == '0);
            end
            sialu_pkg::KIND_MOD: begin
                o.result = abs_word(r.operand_a
                    - mul_word(div_word(r.operand_a, r.operand_b), r.operand_b));
                o.divide_by_zero = (r.operand_b == '0);
            end
            default: ;
        endcase
        return o;
    endfunction

    initial begin
        o_fail_count = 0;
        o_result_count = 0;
    end

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        sialu_pkg::t_rsp exp_rsp;
        int              errs;
        errs = 0;
        if (i_rst_n) begin
            if (i_rsp.valid && i_rsp.ready) begin
                o_result_count <= o_result_count + 1;
                if (expected_q.size() == 0) begin
                    $error("result with no request waiting: %h", i_rsp.data);
                    errs++;
                end else begin
                    exp_rsp = expected_q.pop_front();
                    if (i_rsp.data.result !== exp_rsp.result) begin
                        $error("result: expected %h actual %h", exp_rsp.result,
                               i_rsp.data.result);
                        errs++;
                    end
                    if (i_rsp.data.divide_by_zero !== exp_rsp.divide_by_zero) begin
                        $error("divide_by_zero: expected %b actual %b",
                               exp_rsp.divide_by_zero, i_rsp.data.divide_by_zero);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                o_fail_count <= o_fail_count + errs;
            if (i_req.valid && i_req.ready)
                expected_q.push_back(alu_result(i_req.data));
        end
    end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// directed and random requests to the signed alu with random gaps and stalls
// ----------------------------------------------------------------------------
module testbench;

    localparam sialu_pkg::t_word MIN_WORD = {1'b1, {(sialu_pkg::WORD_BITS-1){1'b0}}};
    localparam sialu_pkg::t_word MAX_WORD = {1'b0, {(sialu_pkg::WORD_BITS-1){1'b1}}};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   result_count;
    int   request_count = 0;

    sialu_req_if req_ch ();
    sialu_rsp_if rsp_ch ();

    signed_integer_alu_mul_div dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    sialu_check checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req_ch),
        .i_rsp          (rsp_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
    end

    // result side stalls
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk iff rsp_ch.valid);
        end
    end

    task automatic send_request(sialu_pkg::t_kind kind, sialu_pkg::t_word a,
                                sialu_pkg::t_word b, int gap);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= '{kind: kind, operand_a: a, operand_b: b};
        @(posedge i_clk iff req_ch.ready);
        request_count++;
    endtask

    function automatic sialu_pkg::t_word random_operand();
        case ($urandom_range(0, 5))
            0: return MIN_WORD;
            1: return MAX_WORD;
            2: return sialu_pkg::t_word'($urandom_range(0, 20));
            3: return -sialu_pkg::t_word'($urandom_range(0, 20));
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int               burst;
        sialu_pkg::t_kind k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(sialu_pkg::KIND_ADD, MAX_WORD, 32'd1, 0);
        send_request(sialu_pkg::KIND_ADD, '1, '1, 0);
        send_request(sialu_pkg::KIND_SUB, MIN_WORD, 32'd1, 0);
        send_request(sialu_pkg::KIND_SUB, '0, '1, 1);
        send_request(sialu_pkg::KIND_MUL, MIN_WORD, '1, 0);
        send_request(sialu_pkg::KIND_MUL, -32'sd7, 32'd6, 0);
        send_request(sialu_pkg::KIND_MUL, '1, '1, 2);
        send_request(sialu_pkg::KIND_MUL, MAX_WORD, MAX_WORD, 0);
        send_request(sialu_pkg::KIND_DIV, MIN_WORD, '1, 0);
        send_request(sialu_pkg::KIND_DIV, -32'sd7, 32'd2, 0);
        send_request(sialu_pkg::KIND_DIV, 32'd7, '0, 0);
        send_request(sialu_pkg::KIND_DIV, -32'sd7, '0, 3);
        send_request(sialu_pkg::KIND_DIV, MAX_WORD, MIN_WORD, 0);
        send_request(sialu_pkg::KIND_MOD, -32'sd7, 32'd2, 0);
        send_request(sialu_pkg::KIND_MOD, MIN_WORD, '0, 0);
        send_request(sialu_pkg::KIND_MOD, 32'd9, '0, 0);
        send_request(sialu_pkg::KIND_MOD, MIN_WORD, 32'd3, 0);
        send_request(sialu_pkg::KIND_MOD, MIN_WORD, '1, 0);
        send_request(sialu_pkg::t_kind'(5), '1, '1, 0);
        send_request(sialu_pkg::t_kind'(6), 32'd5, '0, 0);
        send_request(sialu_pkg::t_kind'(7), '1, '0, 0);

        // hold off until the pipeline drains
        req_ch.valid <= 1'b0;
        wait (pending == 0);
        @(posedge i_clk);

        while (request_count < 520) begin
            burst = $urandom_range(0, 4);
            k = ($urandom_range(0, 15) == 0) ? sialu_pkg::t_kind'($urandom_range(5, 7))
                                            : sialu_pkg::t_kind'($urandom_range(0, 4));
            send_request(k,
                         ($urandom_range(0, 1) != 0) ? $urandom() : random_operand(),
                         ($urandom_range(0, 1) != 0) ? $urandom() : random_operand(),
                         (burst == 0) ? 0 : $urandom_range(0, 9));
        end
        req_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (50) @(posedge i_clk);
        $display("%0d requests sent, %0d results checked: all operations, extremes,",
                 request_count, result_count);
        $display("division by zero and unused kinds under random gaps and stalls");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
